@@ sv/lamts_pkg.sv @@
// ----------------------------------------------------------------------------
// lamts_pkg: shared types, constants and tables for the link adaptation block
// Holds the MCS threshold table, the scaled spectral efficiency table, the
// Doppler spacing boundaries and the queue entry type.
// ----------------------------------------------------------------------------
package lamts_pkg;

  // Field widths
  localparam int unsigned SinrW    = 11;
  localparam int unsigned BandsW   = 8;
  localparam int unsigned SymsW    = 4;
  localparam int unsigned DopplerW = 24;
  localparam int unsigned McsW     = 5;
  localparam int unsigned TbW      = 17;
  localparam int unsigned ScsW     = 3;
  localparam int unsigned BlerW    = 2;

  // Derived widths
  localparam int unsigned EffW     = SinrW + 1;        // SINR after back-off
  localparam int unsigned AllocW   = BandsW + SymsW;   // sub-bands * symbols
  localparam int unsigned Se3W     = 21;               // 3 * SE in Q4.16
  localparam int unsigned ProdW    = Se3W + AllocW;
  localparam int unsigned SeFracW  = 16;

  // Number of MCS levels in use
  localparam int unsigned TableSize = 29;
  localparam int unsigned McsLevels = 29;

  // BLER class codes
  localparam logic [BlerW-1:0] BlerNone = 2'd0;
  localparam logic [BlerW-1:0] BlerMid  = 2'd1;
  localparam logic [BlerW-1:0] BlerLow  = 2'd2;

  // Back-off in tenths of a dB
  localparam logic signed [EffW-1:0] BackoffNone = 12'sd0;
  localparam logic signed [EffW-1:0] BackoffMid  = 12'sd15;
  localparam logic signed [EffW-1:0] BackoffLow  = 12'sd30;

  // Ascending SINR thresholds in tenths of a dB
  localparam logic signed [EffW-1:0] SinrThr [TableSize] = '{
    -12'sd67, -12'sd47, -12'sd23,  12'sd2,   12'sd24,  12'sd43,  12'sd59,
     12'sd81,  12'sd103, 12'sd117, 12'sd141, 12'sd156, 12'sd170, 12'sd188,
     12'sd204, 12'sd218, 12'sd234, 12'sd251, 12'sd268, 12'sd282, 12'sd294,
     12'sd306, 12'sd317, 12'sd328, 12'sd338, 12'sd350, 12'sd360, 12'sd375,
     12'sd390
  };

  // Spectral efficiency in Q4.16 times 3 (24 bits per RE-group over 8 bits)
  localparam logic [Se3W-1:0] Se3Table [TableSize] = '{
    21'd46086,   21'd74121,   21'd118278,  21'd172425,  21'd231171,
    21'd290310,  21'd333309,  21'd376326,  21'd424713,  21'd473097,
    21'd505341,  21'd536838,  21'd595584,  21'd653190,  21'd709638,
    21'd767223,  21'd828291,  21'd889338,  21'd946944,  21'd1005690,
    21'd1048314, 21'd1092099, 21'd1131264, 21'd1165827, 21'd1196163,
    21'd1224198, 21'd1248009, 21'd1268730, 21'd1288707
  };

  // Doppler boundaries in Hz; a boundary belongs to the higher code
  localparam int unsigned ScsBounds = 6;
  localparam logic [DopplerW-1:0] DopplerBound [ScsBounds] = '{
    24'd1500, 24'd3000, 24'd6000, 24'd12000, 24'd24000, 24'd48000
  };

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  // One classified request
  typedef struct packed {
    logic [McsW-1:0]   mcs;
    logic [AllocW-1:0] alloc;
    logic [ScsW-1:0]   scs;
  } job_t;

endpackage

@@ sv/lamts_req_if.sv @@
// ----------------------------------------------------------------------------
// lamts_req_if: request channel
// Valid/ready channel carrying one link adaptation request.
// ----------------------------------------------------------------------------
interface lamts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lamts_pkg::SinrW-1:0]   sinr_tenth_db;
  logic [lamts_pkg::BandsW-1:0]         sub_band_count;
  logic [lamts_pkg::SymsW-1:0]          symbol_count;
  logic [lamts_pkg::DopplerW-1:0]       doppler_abs_hz;

  modport source (
    output valid, sinr_tenth_db, sub_band_count, symbol_count, doppler_abs_hz,
    input  ready
  );
  modport sink (
    input  valid, sinr_tenth_db, sub_band_count, symbol_count, doppler_abs_hz,
    output ready
  );
endinterface

@@ sv/lamts_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lamts_rsp_if: response channel
// Valid/ready channel carrying MCS, transport block size and spacing code.
// ----------------------------------------------------------------------------
interface lamts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lamts_pkg::McsW-1:0]    mcs_index;
  logic [lamts_pkg::TbW-1:0]     tb_bytes;
  logic [lamts_pkg::ScsW-1:0]    scs_code;

  modport source (
    output valid, mcs_index, tb_bytes, scs_code,
    input  ready
  );
  modport sink (
    input  valid, mcs_index, tb_bytes, scs_code,
    output ready
  );
endinterface

@@ sv/link_adaptation_mcs_tbs_scs.sv @@
// ----------------------------------------------------------------------------
// link_adaptation_mcs_tbs_scs: link adaptation top level
// Path: a request is written into the queue, then into the result register.
// Throughput: one request per cycle while the sink is ready; the back stage
// loads its result register whenever it pops a job. A stalled result lets two more
// requests into the queue before request ready drops.
// Reset: queue empty, no result valid, bler_class back to 0.
// ----------------------------------------------------------------------------
module link_adaptation_mcs_tbs_scs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lamts_pkg::BlerW-1:0] cfg_wdata_i,
  lamts_req_if.sink                   req_i,
  lamts_rsp_if.source                 rsp_o
);

  logic [lamts_pkg::BlerW-1:0] bler_class_q;
  logic                        push;
  logic                        pop;
  logic                        q_full;
  logic                        q_empty;
  lamts_pkg::job_t             job;
  lamts_pkg::job_t             head;

  // BLER class register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bler_class_q <= lamts_pkg::BlerNone;
    end else if (cfg_we_i) begin
      bler_class_q <= cfg_wdata_i;
    end
  end

  lamts_front u_front (
    .req_i        (req_i),
    .bler_class_i (bler_class_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job)
  );

  lamts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  lamts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

@@ sv/lamts_front.sv @@
// ----------------------------------------------------------------------------
// lamts_front: request classifier
// Accepts requests, picks the MCS from the backed-off SINR, the spacing code
// from the Doppler magnitude and forms the allocation size for the queue.
// ----------------------------------------------------------------------------
module lamts_front (
  lamts_req_if.sink                 req_i,
  input  logic [lamts_pkg::BlerW-1:0] bler_class_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output lamts_pkg::job_t           job_o
);

  logic signed [lamts_pkg::EffW-1:0] backoff;
  logic signed [lamts_pkg::EffW-1:0] eff;
  logic [lamts_pkg::McsW-1:0]        mcs;
  logic [lamts_pkg::ScsW-1:0]        scs;

  // Transfer whenever the queue has room
  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && !q_full_i;

  // Back-off per BLER class; the unused code acts as the strictest class
  always_comb begin
    unique case (bler_class_i)
      lamts_pkg::BlerNone: backoff = lamts_pkg::BackoffNone;
      lamts_pkg::BlerMid:  backoff = lamts_pkg::BackoffMid;
      default:             backoff = lamts_pkg::BackoffLow;
    endcase
  end

  assign eff = lamts_pkg::EffW'(req_i.sinr_tenth_db) - backoff;

  // Thresholds ascend, so the highest met level is the answer
  always_comb begin
    mcs = '0;
    for (int i = 0; i < lamts_pkg::McsLevels; i++) begin
      if (eff >= lamts_pkg::SinrThr[i]) begin
        mcs = lamts_pkg::McsW'(i);
      end
    end
  end

  // Spacing code: number of boundaries reached
  always_comb begin
    scs = '0;
    for (int i = 0; i < lamts_pkg::ScsBounds; i++) begin
      if (req_i.doppler_abs_hz >= lamts_pkg::DopplerBound[i]) begin
        scs = lamts_pkg::ScsW'(i + 1);
      end
    end
  end

  assign job_o.mcs   = mcs;
  assign job_o.alloc = lamts_pkg::AllocW'(req_i.sub_band_count) *
                       lamts_pkg::AllocW'(req_i.symbol_count);
  assign job_o.scs   = scs;

endmodule

@@ sv/lamts_queue.sv @@
// ----------------------------------------------------------------------------
// lamts_queue: job queue
// Small FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module lamts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lamts_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output lamts_pkg::job_t head_o
);

  lamts_pkg::job_t                 mem_q [lamts_pkg::QueueDepth];
  logic [lamts_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lamts_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lamts_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == lamts_pkg::QCntW'(lamts_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ sv/lamts_back.sv @@
// ----------------------------------------------------------------------------
// lamts_back: transport block sizing and result register
// Multiplies the scaled spectral efficiency by the allocation, takes the
// byte count with a floor of one and holds the result for the sink.
// ----------------------------------------------------------------------------
module lamts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lamts_pkg::job_t head_i,
  output logic            pop_o,
  lamts_rsp_if.source     rsp_o
);

  logic                           out_vld_q;
  logic [lamts_pkg::McsW-1:0]     mcs_q;
  logic [lamts_pkg::TbW-1:0]      tb_q, tb_d;
  logic [lamts_pkg::ScsW-1:0]     scs_q;
  logic [lamts_pkg::Se3W-1:0]     se3;
  logic [lamts_pkg::ProdW-1:0]    prod;
  logic [lamts_pkg::TbW-1:0]      tb_raw;

  // Load the output register when it is free or being drained
  assign pop_o = !empty_i && (!out_vld_q || rsp_o.ready);

  // Bytes = floor(3 * SE_q16 * alloc / 2^16), at least one
  assign se3    = lamts_pkg::Se3Table[head_i.mcs];
  assign prod   = lamts_pkg::ProdW'(se3) * lamts_pkg::ProdW'(head_i.alloc);
  assign tb_raw = prod[lamts_pkg::ProdW-1:lamts_pkg::SeFracW];
  assign tb_d   = (tb_raw == '0) ? lamts_pkg::TbW'(1) : tb_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop_o) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mcs_q <= head_i.mcs;
      tb_q  <= tb_d;
      scs_q <= head_i.scs;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.mcs_index = mcs_q;
  assign rsp_o.tb_bytes  = tb_q;
  assign rsp_o.scs_code  = scs_q;

  // A block of zero bytes is never reported
  a_tb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (tb_q != '0))
    else $error("zero transport block size");

  // MCS stays within the configured levels
  a_mcs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (mcs_q < lamts_pkg::McsW'(lamts_pkg::McsLevels)))
    else $error("MCS out of range");

  // A popped job always shows up at the output in the next cycle
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_vld_q)
    else $error("popped job lost");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: link adaptation block testbench
// Drives SINR / allocation / Doppler requests with random gaps on both
// channels, predicts MCS, transport block bytes and spacing code per request,
// and checks every response in order across all BLER class settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [lamts_pkg::BlerW-1:0] BlerSpare = 2'd3;   // unused code, acts as 3 dB
  localparam int unsigned PhaseItems = 120;
  localparam int unsigned HoldAt     = 300;        // requests before the long hold
  localparam int unsigned HoldLen    = 90;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic signed [lamts_pkg::SinrW-1:0] sinr;
    logic [lamts_pkg::BandsW-1:0]       bands;
    logic [lamts_pkg::SymsW-1:0]        syms;
    logic [lamts_pkg::DopplerW-1:0]     doppler;
  } la_req_t;

  typedef struct {
    logic [lamts_pkg::McsW-1:0] mcs;
    logic [lamts_pkg::TbW-1:0]  tb;
    logic [lamts_pkg::ScsW-1:0] scs;
  } la_rsp_t;

  // MCS thresholds in tenths of a dB and spectral efficiency in Q4.16
  const int mcs_floor_tenths [29] = '{
    -67, -47, -23, 2, 24, 43, 59, 81, 103, 117,
    141, 156, 170, 188, 204, 218, 234, 251, 268, 282,
    294, 306, 317, 328, 338, 350, 360, 375, 390
  };
  const longint unsigned se_q16 [29] = '{
    15362, 24707, 39426, 57475, 77057, 96770, 111103,
    125442, 141571, 157699, 168447, 178946, 198528, 217730,
    236546, 255741, 276097, 296446, 315648, 335230, 349438,
    364033, 377088, 388609, 398721, 408066, 416003, 422910, 429569
  };
  const int unsigned scs_edge_hz [6] = '{1500, 3000, 6000, 12000, 24000, 48000};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [lamts_pkg::BlerW-1:0] cfg_wdata_i;

  lamts_req_if req_if ();
  lamts_rsp_if rsp_if ();

  link_adaptation_mcs_tbs_scs dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  la_req_t pending_reqs [$];
  la_rsp_t link_expect_q [$];
  logic [lamts_pkg::BlerW-1:0] bler_shadow;
  logic req_took;
  int unsigned req_count;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int backoff_tenths(input logic [lamts_pkg::BlerW-1:0] cls);
    if (cls == lamts_pkg::BlerNone) return 0;
    if (cls == lamts_pkg::BlerMid) return 15;
    return 30;
  endfunction

  // Expected MCS, transport block size and spacing for one request
  function automatic la_rsp_t select_link(input la_req_t rq,
                                          input logic [lamts_pkg::BlerW-1:0] cls);
    int eff;
    int unsigned lvl;
    bit climbing;
    longint unsigned bytes;
    la_rsp_t r;
    eff = int'(rq.sinr) - backoff_tenths(cls);
    lvl = 0;
    climbing = 1'b1;
    for (int i = 0; i < 29; i++) begin
      if (climbing && eff >= mcs_floor_tenths[i]) lvl = i;
      else climbing = 1'b0;
    end
    bytes = (se_q16[lvl] * longint'(rq.bands) * longint'(rq.syms) * 3) >> 16;
    if (bytes < 1) bytes = 1;
    if (bytes > 131071) bytes = 131071;
    r.mcs = lvl[lamts_pkg::McsW-1:0];
    r.tb  = bytes[lamts_pkg::TbW-1:0];
    r.scs = '0;
    for (int i = 0; i < 6; i++) begin
      if (rq.doppler >= scs_edge_hz[i]) r.scs = lamts_pkg::ScsW'(i + 1);
    end
    return r;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic add_req(input int sinr, input int unsigned bands, input int unsigned syms,
                         input int unsigned doppler);
    la_req_t rq;
    rq.sinr    = sinr[lamts_pkg::SinrW-1:0];
    rq.bands   = bands[lamts_pkg::BandsW-1:0];
    rq.syms    = syms[lamts_pkg::SymsW-1:0];
    rq.doppler = doppler[lamts_pkg::DopplerW-1:0];
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Random request, mostly aimed at MCS thresholds and often at spacing boundaries
  task automatic add_random_req();
    int sinr;
    int unsigned bands;
    int unsigned doppler;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      sinr = mcs_floor_tenths[$urandom_range(28)] + backoff_tenths(bler_shadow)
             + int'($urandom_range(4)) - 2;
    end else begin
      sinr = int'($urandom_range(2047)) - 1024;
    end
    r = $urandom_range(99);
    if (r < 10) bands = 0;
    else if (r < 20) bands = 255;
    else bands = $urandom_range(255);
    r = $urandom_range(99);
    if (r < 40) doppler = scs_edge_hz[$urandom_range(5)] + $urandom_range(4) - 2;
    else if (r < 70) doppler = $urandom_range(60000);
    else doppler = $urandom_range(24'hFFFFFF);
    add_req(sinr, bands, $urandom_range(15), doppler);
  endtask

  // Wait until every request has gone through and its response has come back
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || link_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_bler(input logic [lamts_pkg::BlerW-1:0] cls);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cls;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    bler_shadow = cls;
  endtask

  // Request driver: offers pending items, holds until the transfer
  int unsigned src_gap = 0;
  int unsigned src_cycle = 0;
  bit src_calm = 1'b0;
  la_req_t src_item;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (src_cycle % 64 == 0) src_calm = ($urandom_range(3) == 0);
      src_cycle++;
      if (req_if.valid && !req_took) begin
        // still waiting for the transfer
      end else if (src_gap > 0) begin
        src_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        src_item = pending_reqs.pop_front();
        req_if.sinr_tenth_db  <= src_item.sinr;
        req_if.sub_band_count <= src_item.bands;
        req_if.symbol_count   <= src_item.syms;
        req_if.doppler_abs_hz <= src_item.doppler;
        req_if.valid          <= 1'b1;
        src_gap = pick_gap(src_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls plus one long hold while requests keep coming
  int unsigned snk_gap = 0;
  int unsigned snk_cycle = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit snk_calm = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (snk_cycle % 64 == 0) snk_calm = ($urandom_range(3) == 0);
      snk_cycle++;
      if (!hold_done && req_count >= HoldAt) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        snk_gap = pick_gap(snk_calm);
      end
    end
  end

  // Monitor: predict on request transfer, check on response transfer
  la_req_t mon_req;
  la_rsp_t mon_exp;

  always @(posedge clk_i) begin
    req_took <= req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        mon_req.sinr    = req_if.sinr_tenth_db;
        mon_req.bands   = req_if.sub_band_count;
        mon_req.syms    = req_if.symbol_count;
        mon_req.doppler = req_if.doppler_abs_hz;
        link_expect_q.insert(link_expect_q.size(), select_link(mon_req, bler_shadow));
        req_count++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (link_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("[%0t] unexpected response: mcs %0d tb %0d scs %0d", $realtime,
                     rsp_if.mcs_index, rsp_if.tb_bytes, rsp_if.scs_code);
        end else begin
          mon_exp = link_expect_q.pop_front();
          if (rsp_if.mcs_index !== mon_exp.mcs || rsp_if.tb_bytes !== mon_exp.tb ||
              rsp_if.scs_code !== mon_exp.scs) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("[%0t] expected mcs %0d tb %0d scs %0d, got mcs %0d tb %0d scs %0d",
                       $realtime, mon_exp.mcs, mon_exp.tb, mon_exp.scs,
                       rsp_if.mcs_index, rsp_if.tb_bytes, rsp_if.scs_code);
          end
        end
      end
    end
    // watchdog on cycles without any transfer
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus and phase sequencing
  initial begin
    logic [lamts_pkg::BlerW-1:0] phase_cls [5];
    phase_cls = '{BlerSpare, lamts_pkg::BlerMid, lamts_pkg::BlerNone, lamts_pkg::BlerLow,
                  BlerSpare};
    req_count   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    req_took    = 1'b0;
    bler_shadow = lamts_pkg::BlerNone;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = lamts_pkg::BlerNone;
    req_if.valid          = 1'b0;
    req_if.sinr_tenth_db  = '0;
    req_if.sub_band_count = '0;
    req_if.symbol_count   = '0;
    req_if.doppler_abs_hz = '0;
    rsp_if.ready          = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes and threshold / spacing edges, reset class
    add_req(-1024, 255, 14, 0);          // nothing met
    add_req(1023, 255, 14, 24'hFFFFFF);  // top MCS, top spacing
    add_req(1023, 255, 15, 48000);       // symbols above 14
    add_req(390, 0, 14, 47999);          // zero sub-bands
    add_req(390, 200, 0, 1500);          // zero symbols
    add_req(0, 0, 0, 0);
    add_req(-67, 1, 1, 1499);
    add_req(-68, 1, 1, 1500);
    add_req(389, 255, 15, 2999);
    add_req(2, 10, 7, 3000);
    add_req(1, 10, 7, 5999);
    add_req(24, 100, 12, 6000);
    add_req(23, 100, 12, 11999);
    add_req(360, 255, 14, 12000);
    add_req(375, 128, 8, 23999);
    add_req(374, 127, 9, 24000);
    add_req(-1, 1, 1, 1);
    add_req(-24, 85, 5, 24'h800000);
    add_req(-1024, 255, 15, 24'h7FFFFF);
    add_req(1023, 0, 0, 24'h555555);
    drain();

    // random phases over all BLER classes
    foreach (phase_cls[p]) begin
      write_bler(phase_cls[p]);
      repeat (PhaseItems) add_random_req();
      drain();
    end

    if (mismatches == 0 && link_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lamts_pkg.sv
sv/lamts_req_if.sv
sv/lamts_rsp_if.sv
sv/lamts_front.sv
sv/lamts_queue.sv
sv/lamts_back.sv
sv/link_adaptation_mcs_tbs_scs.sv
dv/tb_top.sv
